@@ rtl/core/dcp_pkg.sv @@
// Shared types, constants and the control store of the delta correlation prefetcher.
// Used by dcp_useq, dcp_datapath and the core top level; depends on nothing else.
package dcp_pkg;

    localparam int DELTA_W     = 32;
    localparam int ADDR_W      = 64;
    localparam int ACT_W       = 2;
    localparam int HLEN_W      = 6;
    localparam int PDEPTH_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - 2;

    localparam logic [HLEN_W-1:0]   HLEN_RST   = 6'd32;
    localparam logic [PDEPTH_W-1:0] PDEPTH_RST = 5'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PF_DEPTH = 2'd1;

    typedef enum logic [1:0] {
        ACT_RECORD  = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        L_IDLE    = 4'd0,
        L_PRIME   = 4'd1,
        L_FULL    = 4'd2,
        L_REC     = 4'd3,
        L_CMP     = 4'd4,
        L_RDONE   = 4'd5,
        L_CLEAR   = 4'd6,
        L_NONE    = 4'd7,
        L_EMIT1   = 4'd8,
        L_STRIDE  = 4'd9,
        L_REPLAY  = 4'd10,
        L_PF_RD   = 4'd11,
        L_PF_ADD  = 4'd12,
        L_PF_EMIT = 4'd13,
        L_PF_NEXT = 4'd14,
        L_RET     = 4'd15
    } t_upc;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_PRIME     = 4'd1,
        OP_FULL      = 4'd2,
        OP_REC       = 4'd3,
        OP_CMP       = 4'd4,
        OP_RDONE     = 4'd5,
        OP_CLEAR     = 4'd6,
        OP_ZERO      = 4'd7,
        OP_EMIT1     = 4'd8,
        OP_PF_INIT_S = 4'd9,
        OP_PF_INIT_R = 4'd10,
        OP_RD        = 4'd11,
        OP_ADD       = 4'd12,
        OP_PF_EMIT   = 4'd13
    } t_op;

    typedef enum logic [2:0] {
        NX_NEXT = 3'd0,
        NX_JUMP = 3'd1,
        NX_COND = 3'd2,
        NX_WAIT = 3'd3,
        NX_DISP = 3'd4
    } t_nx;

    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_OUT_FREE = 3'd1,
        C_K_LAST   = 3'd2,
        C_PF_MORE  = 3'd3,
        C_SHORT    = 3'd4
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_nx   nx;
        t_cond cond;
        t_upc  target;
        logic  in_ready;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctrl;

    typedef struct packed {
        logic primed;
        logic full;
        logic stride_lk;
        logic pat_ok;
        logic depth_zero;
        logic short_hist;
        logic k_last;
        logic pf_more;
        logic out_free;
    } t_stat;

    function automatic t_uword mk(input t_op op, input t_nx nx, input t_cond cond,
                                  input t_upc target, input logic rdy);
        t_uword w;
        w.op       = op;
        w.nx       = nx;
        w.cond     = cond;
        w.target   = target;
        w.in_ready = rdy;
        return w;
    endfunction

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            L_IDLE:    w = mk(OP_NOP,       NX_DISP, C_ALWAYS,   L_IDLE,    1'b1);
            L_PRIME:   w = mk(OP_PRIME,     NX_JUMP, C_ALWAYS,   L_EMIT1,   1'b0);
            L_FULL:    w = mk(OP_FULL,      NX_JUMP, C_ALWAYS,   L_EMIT1,   1'b0);
            L_REC:     w = mk(OP_REC,       NX_COND, C_SHORT,    L_EMIT1,   1'b0);
            L_CMP:     w = mk(OP_CMP,       NX_WAIT, C_K_LAST,   L_RDONE,   1'b0);
            L_RDONE:   w = mk(OP_RDONE,     NX_JUMP, C_ALWAYS,   L_EMIT1,   1'b0);
            L_CLEAR:   w = mk(OP_CLEAR,     NX_JUMP, C_ALWAYS,   L_EMIT1,   1'b0);
            L_NONE:    w = mk(OP_ZERO,      NX_JUMP, C_ALWAYS,   L_EMIT1,   1'b0);
            L_EMIT1:   w = mk(OP_EMIT1,     NX_WAIT, C_OUT_FREE, L_IDLE,    1'b0);
            L_STRIDE:  w = mk(OP_PF_INIT_S, NX_JUMP, C_ALWAYS,   L_PF_RD,   1'b0);
            L_REPLAY:  w = mk(OP_PF_INIT_R, NX_NEXT, C_ALWAYS,   L_PF_RD,   1'b0);
            L_PF_RD:   w = mk(OP_RD,        NX_NEXT, C_ALWAYS,   L_PF_ADD,  1'b0);
            L_PF_ADD:  w = mk(OP_ADD,       NX_NEXT, C_ALWAYS,   L_PF_EMIT, 1'b0);
            L_PF_EMIT: w = mk(OP_PF_EMIT,   NX_WAIT, C_OUT_FREE, L_PF_NEXT, 1'b0);
            L_PF_NEXT: w = mk(OP_NOP,       NX_COND, C_PF_MORE,  L_PF_RD,   1'b0);
            L_RET:     w = mk(OP_NOP,       NX_JUMP, C_ALWAYS,   L_IDLE,    1'b0);
            default:   w = mk(OP_NOP,       NX_JUMP, C_ALWAYS,   L_IDLE,    1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] sext_delta(input logic [DELTA_W-1:0] d);
        return {{(ADDR_W-DELTA_W){d[DELTA_W-1]}}, d};
    endfunction

endpackage

@@ rtl/core/dcp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the delta history of the prefetcher.
module dcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/dcp_useq.sv @@
// Micro-sequencer: step counter, control store lookup, condition select and dispatch.
// Depends on dcp_pkg for the control word, label and status types.
module dcp_useq import dcp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_acc,
    input  logic [ACT_W-1:0]  i_action,
    input  t_stat             i_stat,
    output t_ctrl             o_ctrl
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_upc   w_disp;
    t_upc   w_inc;
    t_uword w_uw;
    logic   w_cond;

    assign w_uw  = ucode(r_upc);
    assign w_inc = t_upc'(4'(r_upc + 4'd1));

    always_comb begin
        case (w_uw.cond)
            C_ALWAYS:   w_cond = 1'b1;
            C_OUT_FREE: w_cond = i_stat.out_free;
            C_K_LAST:   w_cond = i_stat.k_last;
            C_PF_MORE:  w_cond = i_stat.pf_more;
            C_SHORT:    w_cond = i_stat.short_hist;
            default:    w_cond = 1'b0;
        endcase
    end

    always_comb begin
        case (t_action'(i_action))
            ACT_RECORD: begin
                if (!i_stat.primed) begin
                    w_disp = L_PRIME;
                end else if (i_stat.full) begin
                    w_disp = L_FULL;
                end else begin
                    w_disp = L_REC;
                end
            end
            ACT_REQUEST: begin
                if (i_stat.depth_zero) begin
                    w_disp = L_NONE;
                end else if (i_stat.stride_lk) begin
                    w_disp = L_STRIDE;
                end else if (i_stat.pat_ok) begin
                    w_disp = L_REPLAY;
                end else begin
                    w_disp = L_NONE;
                end
            end
            ACT_CLEAR: w_disp = L_CLEAR;
            default:   w_disp = L_NONE;
        endcase
    end

    always_comb begin
        case (w_uw.nx)
            NX_NEXT: n_upc = w_inc;
            NX_JUMP: n_upc = w_uw.target;
            NX_COND: n_upc = w_cond ? w_uw.target : w_inc;
            NX_WAIT: n_upc = w_cond ? w_uw.target : r_upc;
            NX_DISP: n_upc = i_in_acc ? w_disp : r_upc;
            default: n_upc = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= L_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl.op       = w_uw.op;
    assign o_ctrl.in_ready = w_uw.in_ready;

endmodule

@@ rtl/core/dcp_datapath.sv @@
// Datapath: configuration, address and delta state, compare windows, history RAM
// and the result register. Depends on dcp_pkg and dcp_ram.
module dcp_datapath import dcp_pkg::*; #(
    parameter int HISTORY_DEPTH = 32,
    parameter int MATCH_DEPTH   = 4,
    parameter int MAX_PREFETCH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    input  logic                  i_in_acc,
    input  logic [ADDR_W-1:0]     i_lba,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic                  o_trig,
    output logic                  o_full,
    output logic                  o_avalid,
    output logic [ADDR_W-1:0]     o_addr,
    output logic                  o_last
);

    localparam int AW      = $clog2(HISTORY_DEPTH);
    localparam int CNT_MAX = (HISTORY_DEPTH > MATCH_DEPTH + 1) ? HISTORY_DEPTH
                                                               : MATCH_DEPTH + 1;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int HCW     = (CW > HLEN_W) ? CW : HLEN_W;
    localparam int KW      = $clog2(MATCH_DEPTH);
    localparam int PW      = ($clog2(MAX_PREFETCH + 1) > PDEPTH_W) ? $clog2(MAX_PREFETCH + 1)
                                                                   : PDEPTH_W;

    logic [HLEN_W-1:0]   r_hist_len,  n_hist_len;
    logic [PDEPTH_W-1:0] r_pf_depth,  n_pf_depth;
    logic [ADDR_W-1:0]   r_lba,       n_lba;
    logic [ADDR_W-1:0]   r_prev,      n_prev;
    logic                r_primed,    n_primed;
    logic [CW-1:0]       r_count,     n_count;
    logic [DELTA_W-1:0]  r_stride,    n_stride;
    logic                r_stride_lk, n_stride_lk;
    logic                r_pat,       n_pat;
    logic                r_match,     n_match;
    logic [KW-1:0]       r_ck,        n_ck;
    logic [DELTA_W-1:0]  r_head [MATCH_DEPTH];
    logic [DELTA_W-1:0]  n_head [MATCH_DEPTH];
    logic [DELTA_W-1:0]  r_tail [MATCH_DEPTH];
    logic [DELTA_W-1:0]  n_tail [MATCH_DEPTH];
    logic                r_trig,      n_trig;
    logic                r_full,      n_full;
    logic [ADDR_W-1:0]   r_addr,      n_addr;
    logic                r_use_str,   n_use_str;
    logic [PW-1:0]       r_pk,        n_pk;
    logic [PW-1:0]       r_n,         n_n;
    logic [AW-1:0]       r_pos,       n_pos;
    logic [AW-1:0]       r_start,     n_start;
    logic                r_ovalid,    n_ovalid;
    logic                r_otrig,     n_otrig;
    logic                r_ofull,     n_ofull;
    logic                r_oavalid,   n_oavalid;
    logic [ADDR_W-1:0]   r_oaddr,     n_oaddr;
    logic                r_olast,     n_olast;

    logic [DELTA_W-1:0]  w_delta;
    logic [DELTA_W-1:0]  w_rdata;
    logic [DELTA_W-1:0]  w_ref;
    logic [HCW-1:0]      w_cap;
    logic [PW-1:0]       w_n_eff;
    logic [AW-1:0]       w_start;
    logic                w_out_free;
    logic                w_cnt_eq_m;
    logic                w_we;
    logic                w_re;

    assign w_delta    = r_prev[DELTA_W-1:0] - r_lba[DELTA_W-1:0];
    assign w_cap      = (HCW'(r_hist_len) > HCW'(HISTORY_DEPTH)) ? HCW'(HISTORY_DEPTH)
                                                                 : HCW'(r_hist_len);
    assign w_n_eff    = (PW'(r_pf_depth) > PW'(MAX_PREFETCH)) ? PW'(MAX_PREFETCH)
                                                              : PW'(r_pf_depth);
    assign w_start    = AW'(r_count - CW'(MATCH_DEPTH + 1));
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_cnt_eq_m = (r_count == CW'(MATCH_DEPTH));
    assign w_ref      = w_cnt_eq_m ? r_stride : r_tail[0];
    assign w_we       = (i_ctrl.op == OP_REC);
    assign w_re       = (i_ctrl.op == OP_RD);

    dcp_ram #(
        .WIDTH(DELTA_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_delta),
        .i_re    (w_re),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_hist_len  = r_hist_len;
        n_pf_depth  = r_pf_depth;
        n_lba       = r_lba;
        n_prev      = r_prev;
        n_primed    = r_primed;
        n_count     = r_count;
        n_stride    = r_stride;
        n_stride_lk = r_stride_lk;
        n_pat       = r_pat;
        n_match     = r_match;
        n_ck        = r_ck;
        n_head      = r_head;
        n_tail      = r_tail;
        n_trig      = r_trig;
        n_full      = r_full;
        n_addr      = r_addr;
        n_use_str   = r_use_str;
        n_pk        = r_pk;
        n_n         = r_n;
        n_pos       = r_pos;
        n_start     = r_start;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_otrig     = r_otrig;
        n_ofull     = r_ofull;
        n_oavalid   = r_oavalid;
        n_oaddr     = r_oaddr;
        n_olast     = r_olast;

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_HIST_LEN) begin
                n_hist_len = i_cfg_data[HLEN_W-1:0];
            end else if (i_cfg_index == CFG_PF_DEPTH) begin
                n_pf_depth = i_cfg_data[PDEPTH_W-1:0];
            end
        end
        if (i_in_acc) begin
            n_lba = i_lba;
        end

        case (i_ctrl.op)
            OP_PRIME: begin
                n_prev   = r_lba;
                n_primed = 1'b1;
                n_trig   = 1'b0;
                n_full   = 1'b0;
            end
            OP_FULL: begin
                n_trig = 1'b0;
                n_full = 1'b1;
            end
            OP_REC: begin
                for (int i = 0; i < MATCH_DEPTH - 1; i++) begin
                    n_tail[i] = r_tail[i+1];
                end
                n_tail[MATCH_DEPTH-1] = w_delta;
                if (r_count < CW'(MATCH_DEPTH)) begin
                    for (int i = 0; i < MATCH_DEPTH - 1; i++) begin
                        n_head[i] = r_head[i+1];
                    end
                    n_head[MATCH_DEPTH-1] = w_delta;
                end
                if (r_count == '0) begin
                    n_stride = w_delta;
                end
                n_count = CW'(r_count + CW'(1));
                n_prev  = r_lba;
                n_trig  = 1'b0;
                n_full  = 1'b0;
                n_match = 1'b1;
                n_ck    = '0;
            end
            OP_CMP: begin
                if (r_head[0] != w_ref) begin
                    n_match = 1'b0;
                end
                for (int i = 0; i < MATCH_DEPTH - 1; i++) begin
                    n_head[i] = r_head[i+1];
                    n_tail[i] = r_tail[i+1];
                end
                n_head[MATCH_DEPTH-1] = r_head[0];
                n_tail[MATCH_DEPTH-1] = r_tail[0];
                n_ck = KW'(r_ck + KW'(1));
            end
            OP_RDONE: begin
                if (w_cnt_eq_m) begin
                    if (r_match) begin
                        n_stride_lk = 1'b1;
                        n_trig      = 1'b1;
                    end
                end else begin
                    n_pat  = r_match;
                    n_trig = r_match;
                end
            end
            OP_CLEAR: begin
                n_prev      = '0;
                n_primed    = 1'b0;
                n_count     = '0;
                n_stride    = '0;
                n_stride_lk = 1'b0;
                n_pat       = 1'b0;
                n_trig      = 1'b0;
                n_full      = 1'b0;
            end
            OP_ZERO: begin
                n_trig = 1'b0;
                n_full = 1'b0;
            end
            OP_EMIT1: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_otrig   = r_trig;
                    n_ofull   = r_full;
                    n_oavalid = 1'b0;
                    n_oaddr   = '0;
                    n_olast   = 1'b1;
                end
            end
            OP_PF_INIT_S, OP_PF_INIT_R: begin
                n_addr    = r_lba;
                n_pk      = '0;
                n_n       = w_n_eff;
                n_use_str = (i_ctrl.op == OP_PF_INIT_S);
                n_pos     = w_start;
                n_start   = w_start;
            end
            OP_ADD: begin
                n_addr = r_addr + (r_use_str ? sext_delta(r_stride) : sext_delta(w_rdata));
            end
            OP_PF_EMIT: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_otrig   = 1'b0;
                    n_ofull   = 1'b0;
                    n_oavalid = 1'b1;
                    n_oaddr   = r_addr;
                    n_olast   = (PW'(r_pk + PW'(1)) == r_n);
                    n_pk      = PW'(r_pk + PW'(1));
                    n_pos     = (r_pos == '0) ? r_start : AW'(r_pos - AW'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len  <= HLEN_RST;
            r_pf_depth  <= PDEPTH_RST;
            r_primed    <= 1'b0;
            r_count     <= '0;
            r_stride_lk <= 1'b0;
            r_pat       <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_hist_len  <= n_hist_len;
            r_pf_depth  <= n_pf_depth;
            r_primed    <= n_primed;
            r_count     <= n_count;
            r_stride_lk <= n_stride_lk;
            r_pat       <= n_pat;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lba     <= n_lba;
        r_prev    <= n_prev;
        r_stride  <= n_stride;
        r_match   <= n_match;
        r_ck      <= n_ck;
        r_head    <= n_head;
        r_tail    <= n_tail;
        r_trig    <= n_trig;
        r_full    <= n_full;
        r_addr    <= n_addr;
        r_use_str <= n_use_str;
        r_pk      <= n_pk;
        r_n       <= n_n;
        r_pos     <= n_pos;
        r_start   <= n_start;
        r_otrig   <= n_otrig;
        r_ofull   <= n_ofull;
        r_oavalid <= n_oavalid;
        r_oaddr   <= n_oaddr;
        r_olast   <= n_olast;
    end

    assign o_stat.primed     = r_primed;
    assign o_stat.full       = (HCW'(r_count) >= w_cap);
    assign o_stat.stride_lk  = r_stride_lk;
    assign o_stat.pat_ok     = r_pat && (r_count > CW'(MATCH_DEPTH));
    assign o_stat.depth_zero = (w_n_eff == '0);
    assign o_stat.short_hist = (r_count < CW'(MATCH_DEPTH - 1));
    assign o_stat.k_last     = (r_ck == KW'(MATCH_DEPTH - 1));
    assign o_stat.pf_more    = (r_pk < r_n);
    assign o_stat.out_free   = w_out_free;

    assign o_valid  = r_ovalid;
    assign o_trig   = r_otrig;
    assign o_full   = r_ofull;
    assign o_avalid = r_oavalid;
    assign o_addr   = r_oaddr;
    assign o_last   = r_olast;

endmodule

@@ rtl/core/delta_correlation_prefetcher_core.sv @@
// Delta correlation prefetcher core. A record goes from accept through prime, full or record to
// the result load, via the compare loop and its done step when history allows; a request runs
// setup, then per prefetch address a history RAM read, add, result load and loop test, then a
// return. Clear, no-operation and empty requests go to a result load. Each result load waits while
// the output holds an item not yet taken; a new item is accepted while the last result waits.
// Synchronous active-low reset clears control state and loads register defaults; history RAM kept.
module delta_correlation_prefetcher_core import dcp_pkg::*; #(
    parameter int HISTORY_DEPTH = 32,
    parameter int MATCH_DEPTH   = 4,
    parameter int MAX_PREFETCH  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [ADDR_W-1:0]      i_s_tdata,   // lba
    input  logic [ACT_W-1:0]       i_s_tuser,   // action
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // triggered, history_full, prefetch_addr, zeros
    output logic [0:0]             o_m_tuser,   // addr_valid
    output logic                   o_m_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_ctrl             w_ctrl;
    t_stat             w_stat;
    logic              w_in_acc;
    logic              w_trig;
    logic              w_full;
    logic              w_avalid;
    logic [ADDR_W-1:0] w_addr;

    assign o_s_tready  = w_ctrl.in_ready;
    assign w_in_acc    = i_s_tvalid && w_ctrl.in_ready;
    assign o_cfg_ready = 1'b1;

    dcp_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_acc (w_in_acc),
        .i_action (i_s_tuser),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl)
    );

    dcp_datapath #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .MATCH_DEPTH  (MATCH_DEPTH),
        .MAX_PREFETCH (MAX_PREFETCH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_in_acc    (w_in_acc),
        .i_lba       (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_stat      (w_stat),
        .o_valid     (o_m_tvalid),
        .o_trig      (w_trig),
        .o_full      (w_full),
        .o_avalid    (w_avalid),
        .o_addr      (w_addr),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, w_addr, w_full, w_trig};
    assign o_m_tuser = w_avalid;

    // Every item moves the sequencer out of its accept step.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("input accepted on two consecutive cycles");

    // Record, clear and no-operation results are always single items.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("non-address result without last");

    // Address results carry no record flags.
    a_addr_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[1:0] == 2'b00))
        else $error("address result with record flags set");

    // A record rejected on a full history never reports a trigger.
    a_full_flag_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> !o_m_tdata[0])
        else $error("history full and triggered on the same result");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for delta_correlation_prefetcher_core: a directed table, then
// random record/request/clear/no-operation traffic under several register settings, checked item by item.
// Depends on dcp_pkg and the core top level only.
module tb_top;
    import dcp_pkg::*;

    localparam int MATCH  = 4;
    localparam int HDEPTH = 32;
    localparam int MAXPF  = 16;
    localparam int NPHASE = 6;

    typedef struct packed {
        logic        trig;
        logic        full;
        logic        avalid;
        logic [63:0] addr;
        logic        last;
    } t_forecast;

    typedef struct {
        t_action     act;
        logic [63:0] lba;
        bit          typed;
        t_forecast   res;
    } t_row;

    localparam t_forecast RES_PLAIN = {3'b000, 64'd0, 1'b1};
    localparam t_forecast RES_TRIG  = {3'b100, 64'd0, 1'b1};
    localparam t_forecast RES_FULL  = {3'b010, 64'd0, 1'b1};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [ADDR_W-1:0]      s_tdata = '0;
    logic [ACT_W-1:0]       s_tuser = '0;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [0:0]             o_m_tuser;
    logic                   o_m_tlast;
    logic                   o_cfg_ready;

    delta_correlation_prefetcher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Shadow state of the prefetcher.
    logic [63:0]         prev_addr;
    bit                  have_base;
    int                  n_deltas;
    logic [31:0]         deltas [0:HDEPTH-1];
    bit                  locked;
    bit                  correlated;
    logic [HLEN_W-1:0]   hist_len = HLEN_RST;
    logic [PDEPTH_W-1:0] pf_depth = PDEPTH_RST;

    t_forecast forecast_q [$];
    t_forecast fresh_q [$];
    t_row      plan_q [$];

    bit calm = 1'b0;
    int stall_left = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int trig_seen = 0;
    int full_seen = 0;
    int addr_seen = 0;

    int unsigned hl_plan [0:NPHASE-1] = '{32, 5, 63, 8, 20, 32};
    int unsigned pd_plan [0:NPHASE-1] = '{16, 1, 31, 0, 7, 4};
    logic [31:0] corr_pat [0:MATCH-1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF};

    function automatic logic [63:0] sign_widen(input logic [31:0] d);
        return {{32{d[31]}}, d};
    endfunction

    function automatic void add_forecast(input logic trig, input logic full,
                                         input logic avalid, input logic [63:0] addr,
                                         input logic last);
        fresh_q.push_back({trig, full, avalid, addr, last});
    endfunction

    function automatic void forecast_prefetch(input t_action act, input logic [63:0] lba);
        int          cap;
        int          n;
        int          start;
        int          pos;
        logic [63:0] step;
        logic [63:0] addr;
        bit          hit;
        cap = (hist_len < HDEPTH) ? int'(hist_len) : HDEPTH;
        n   = (pf_depth < MAXPF) ? int'(pf_depth) : MAXPF;
        case (act)
            ACT_RECORD: begin
                if (!have_base) begin
                    prev_addr = lba;
                    have_base = 1'b1;
                    add_forecast(1'b0, 1'b0, 1'b0, 64'd0, 1'b1);
                end else if (n_deltas >= cap) begin
                    add_forecast(1'b0, 1'b1, 1'b0, 64'd0, 1'b1);
                end else begin
                    deltas[n_deltas] = prev_addr[31:0] - lba[31:0];
                    prev_addr = lba;
                    n_deltas++;
                    hit = 1'b0;
                    if (n_deltas == MATCH) begin
                        hit = 1'b1;
                        for (int k = 1; k < MATCH; k++)
                            if (deltas[k] != deltas[0]) hit = 1'b0;
                        if (hit) locked = 1'b1;
                    end else if (n_deltas > MATCH) begin
                        correlated = 1'b1;
                        for (int k = 0; k < MATCH; k++)
                            if (deltas[k] != deltas[n_deltas - MATCH + k]) correlated = 1'b0;
                        hit = correlated;
                    end
                    add_forecast(hit, 1'b0, 1'b0, 64'd0, 1'b1);
                end
            end
            ACT_REQUEST: begin
                if (n > 0 && locked) begin
                    step = sign_widen(deltas[0]);
                    for (int k = 0; k < n; k++)
                        add_forecast(1'b0, 1'b0, 1'b1, lba + 64'(k + 1) * step, k == n - 1);
                end else if (n > 0 && correlated && n_deltas > MATCH) begin
                    start = n_deltas - MATCH - 1;
                    pos   = start;
                    addr  = lba;
                    for (int k = 0; k < n; k++) begin
                        addr = addr + sign_widen(deltas[pos]);
                        add_forecast(1'b0, 1'b0, 1'b1, addr, k == n - 1);
                        pos = (pos == 0) ? start : pos - 1;
                    end
                end else begin
                    add_forecast(1'b0, 1'b0, 1'b0, 64'd0, 1'b1);
                end
            end
            ACT_CLEAR: begin
                prev_addr  = '0;
                have_base  = 1'b0;
                n_deltas   = 0;
                locked     = 1'b0;
                correlated = 1'b0;
                add_forecast(1'b0, 1'b0, 1'b0, 64'd0, 1'b1);
            end
            default: add_forecast(1'b0, 1'b0, 1'b0, 64'd0, 1'b1);
        endcase
    endfunction

    task automatic send_item(input t_action act, input logic [63:0] lba,
                             input bit typed, input t_forecast typed_res);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= lba;
        do @(posedge i_clk); while (!o_s_tready);
        fresh_q.delete();
        forecast_prefetch(act, lba);
        if (typed) begin
            forecast_q.push_back(typed_res);
        end else begin
            foreach (fresh_q[k]) forecast_q.push_back(fresh_q[k]);
        end
        items_sent++;
    endtask

    task automatic push_item(input t_action act, input logic [63:0] lba);
        send_item(act, lba, 1'b0, RES_PLAIN);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        while (forecast_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HIST_LEN) hist_len = val[HLEN_W-1:0];
        else if (idx == CFG_PF_DEPTH) pf_depth = val[PDEPTH_W-1:0];
    endtask

    function automatic logic [63:0] rand_lba();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 4))
            0:       return 32'($signed($urandom_range(0, 128)) - 64);
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_traffic(input int budget);
        int          used;
        int          len;
        int          p;
        int          cap;
        logic [63:0] cur;
        logic [31:0] pat [0:4];
        used = 0;
        while (used < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                push_item(ACT_CLEAR, rand_lba());
                cur = rand_lba();
                push_item(ACT_RECORD, cur);
                used += 2;
                p = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 5);
                for (int k = 0; k < p; k++) pat[k] = pick_delta();
                if (p > 1) pat[1] = ~pat[0];
                cap = (hist_len < HDEPTH) ? int'(hist_len) : HDEPTH;
                if (cap <= 12 && $urandom_range(0, 1) == 0) len = cap + $urandom_range(1, 3);
                else len = $urandom_range(MATCH, MATCH + 2 * p + 1);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 11) == 0) cur = cur - sign_widen(pick_delta());
                    else cur = cur - sign_widen(pat[k % p]);
                    push_item(ACT_RECORD, cur);
                    used++;
                    if ($urandom_range(0, 7) == 0) begin
                        push_item(ACT_REQUEST, rand_lba());
                        used++;
                    end
                end
                repeat ($urandom_range(1, 2)) begin
                    push_item(ACT_REQUEST, ($urandom_range(0, 1) == 0) ? cur : rand_lba());
                    used++;
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    push_item(t_action'($urandom_range(0, 3)), rand_lba());
                    used++;
                end
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_forecast want, input t_forecast got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s mismatch: expected trig=%0b full=%0b valid=%0b addr=%h ",
                      "last=%0b, got trig=%0b full=%0b valid=%0b addr=%h last=%0b"},
                     $time, what, want.trig, want.full, want.avalid, want.addr, want.last,
                     got.trig, got.full, got.avalid, got.addr, got.last);
    endtask

    always @(posedge i_clk) begin
        t_forecast got;
        t_forecast want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = {o_m_tdata[0], o_m_tdata[1], o_m_tuser[0], o_m_tdata[ADDR_W+1:2], o_m_tlast};
            results_seen++;
            trig_seen += got.trig;
            full_seen += got.full;
            addr_seen += got.avalid;
            if (forecast_q.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = forecast_q.pop_front();
                if (got !== want || o_m_tdata[OUT_TDATA_W-1:ADDR_W+2] !== '0)
                    note_mismatch("result", want, got);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        logic [63:0] cur;
        plan_q.push_back('{ACT_REQUEST, 64'd0, 1'b1, RES_PLAIN});
        plan_q.push_back('{ACT_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, RES_PLAIN});
        cur = 64'hFFFF_FFFF_FFFF_FFFF;
        plan_q.push_back('{ACT_RECORD, cur, 1'b1, RES_PLAIN});
        for (int i = 1; i <= MATCH; i++) begin
            cur = cur - 64'd8;
            plan_q.push_back('{ACT_RECORD, cur, 1'b1, (i == MATCH) ? RES_TRIG : RES_PLAIN});
        end
        plan_q.push_back('{ACT_REQUEST, 64'd0, 1'b0, RES_PLAIN});
        plan_q.push_back('{ACT_REQUEST, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, RES_PLAIN});
        plan_q.push_back('{ACT_CLEAR, 64'h5A5A_A5A5_0F0F_F0F0, 1'b1, RES_PLAIN});
        plan_q.push_back('{ACT_REQUEST, cur, 1'b1, RES_PLAIN});
        cur = 64'h8000_0000_0000_0000;
        plan_q.push_back('{ACT_RECORD, cur, 1'b1, RES_PLAIN});
        for (int i = 0; i < 2 * MATCH; i++) begin
            cur = cur - sign_widen(corr_pat[i % MATCH]);
            plan_q.push_back('{ACT_RECORD, cur, 1'b0, RES_PLAIN});
        end
        plan_q.push_back('{ACT_REQUEST, 64'h0123_4567_89AB_CDEF, 1'b0, RES_PLAIN});
        plan_q.push_back('{ACT_CLEAR, 64'd0, 1'b1, RES_PLAIN});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_q[r]) send_item(plan_q[r].act, plan_q[r].lba, plan_q[r].typed, plan_q[r].res);

        for (int ph = 0; ph < NPHASE; ph++) begin
            s_tvalid <= 1'b0;
            write_reg(CFG_HIST_LEN, CFG_DATA_W'(hl_plan[ph]));
            write_reg(CFG_PF_DEPTH, CFG_DATA_W'(pd_plan[ph]));
            calm = (ph == NPHASE - 1);
            random_traffic(20);
        end
        s_tvalid <= 1'b0;

        while (forecast_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Sent %0d items (%0d from the directed table) under %0d register settings.",
                 items_sent, plan_q.size(), NPHASE + 1);
        $display("Checked %0d results: %0d triggers, %0d full-history rejects, %0d addresses.",
                 results_seen, trig_seen, full_seen, addr_seen);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dcp_pkg.sv
rtl/core/dcp_ram.sv
rtl/core/dcp_useq.sv
rtl/core/dcp_datapath.sv
rtl/core/delta_correlation_prefetcher_core.sv
tb/tb_top.sv
